// File: src/psq_pkg.sv
// psq_pkg: shared types and constants for the priority queue with source quota
// depends on nothing; used by psq_cell and priority_queue_with_source_quota_top
`timescale 1ns / 1ps

package psq_pkg;

    localparam int ID_W    = 32;
    localparam int TAG_W   = 16;
    localparam int PRIO_W  = 16;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 7;
    localparam int CNT_OUT_W = 7;
    localparam logic [LIMIT_W-1:0] TOTAL_RESET = 7'd64;

    typedef enum logic [2:0] {
        KIND_ENQ      = 3'd0,
        KIND_RM_ID    = 3'd1,
        KIND_RM_SRC   = 3'd2,
        KIND_RM_CONV  = 3'd3,
        KIND_REPRIO   = 3'd4,
        KIND_POP      = 3'd5,
        KIND_PEEK     = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ID     = 3'd1,
        ST_NO_TAG     = 3'd2,
        ST_EMPTY_TEXT = 3'd3,
        ST_DUPLICATE  = 3'd4,
        ST_FULL       = 3'd5,
        ST_SRC_FULL   = 3'd6,
        ST_NOT_FOUND  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_APPLY,
        S_SORT,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SORT,
        CELL_LOAD_NEW,
        CELL_DROP_ID,
        CELL_DROP_SRC,
        CELL_DROP_CONV,
        CELL_SET_PRIO,
        CELL_DROP_HEAD
    } cell_op_t;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [TAG_W-1:0]         conv;
        logic [TAG_W-1:0]         src;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        tstamp;
    } entry_t;

    typedef struct packed {
        kind_t                    kind;
        logic [ID_W-1:0]          response_id;
        logic [TAG_W-1:0]         conversation_id;
        logic [TAG_W-1:0]         source_id;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0]        created_time;
        logic                     text_empty;
        logic [LIMIT_W-1:0]       per_source_limit;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [ID_W-1:0]          out_id;
        logic [TAG_W-1:0]         out_conversation;
        logic [TAG_W-1:0]         out_source;
        logic signed [PRIO_W-1:0] out_priority;
        logic [TIME_W-1:0]        out_time;
        logic [CNT_OUT_W-1:0]     removed_count;
    } rsp_t;

    typedef struct packed {
        cell_op_t op;
        logic     parity;
        entry_t   key;
    } cell_cmd_t;

    typedef struct packed {
        logic id;
        logic src;
        logic conv;
    } match_t;

    // a strictly ahead of b: higher priority, or same priority and earlier time
    function automatic logic goes_before(input entry_t a, input entry_t b);
        logic r;
        if (a.prio != b.prio)
        begin
            r = (a.prio > b.prio);
        end
        else
        begin
            r = (a.tstamp < b.tstamp);
        end
        return r;
    endfunction

endpackage

// File: src/priority_queue_with_source_quota_top.sv
// a match scan shifts flag bits down toward cell 0 and counts them, then an
// odd-even transposition pass re-sorts and compacts the cells
// a new request is taken only once the previous response has been accepted by out_ready
// reset: queue empty, total limit 64, no clearing pass (slot payloads need no reset)
// depends on psq_pkg and psq_cell
`timescale 1ns / 1ps

module priority_queue_with_source_quota_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  psq_pkg::req_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output psq_pkg::rsp_t                 out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [psq_pkg::LIMIT_W-1:0]   cfg_data
);

    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int RW   = $clog2(QUEUE_DEPTH);
    localparam int LW   = (CW > psq_pkg::LIMIT_W) ? CW : psq_pkg::LIMIT_W;

    // control state
    psq_pkg::state_t            state_reg, state_next;
    psq_pkg::req_t              req_reg;
    psq_pkg::rsp_t              rsp_reg, rsp_next;
    logic [RW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              occ_reg, occ_next;
    logic [CW-1:0]              a_cnt_reg, a_cnt_next;
    logic [CW-1:0]              b_cnt_reg, b_cnt_next;
    logic [QUEUE_DEPTH-1:0]     flag_a_reg, flag_a_next;
    logic [QUEUE_DEPTH-1:0]     flag_b_reg, flag_b_next;
    logic [psq_pkg::LIMIT_W-1:0] total_reg;

    // cell chain
    psq_pkg::cell_cmd_t         cmd;
    psq_pkg::entry_t            cell_ent [QUEUE_DEPTH];
    logic                       cell_vld [QUEUE_DEPTH];
    logic                       cell_swap [QUEUE_DEPTH];
    psq_pkg::match_t            cell_m [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]     vec_id, vec_src, vec_conv;

    logic                       last_round;
    logic [LW-1:0]              total_lim, src_lim;
    psq_pkg::entry_t            new_ent;

    assign in_ready  = (state_reg == psq_pkg::S_IDLE);
    assign out_valid = (state_reg == psq_pkg::S_RESP);
    assign out_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    assign last_round = (cnt_reg == RW'(QUEUE_DEPTH - 1));

    assign new_ent.id     = req_reg.response_id;
    assign new_ent.conv   = req_reg.conversation_id;
    assign new_ent.src    = req_reg.source_id;
    assign new_ent.prio   = req_reg.priority_req;
    assign new_ent.tstamp = req_reg.created_time;

    // total limit clamped to 1..QUEUE_DEPTH, source limit to at least 1
    always_comb
    begin
        if (total_reg == '0)
        begin
            total_lim = LW'(1);
        end
        else if (LW'(total_reg) > LW'(QUEUE_DEPTH))
        begin
            total_lim = LW'(QUEUE_DEPTH);
        end
        else
        begin
            total_lim = LW'(total_reg);
        end
        src_lim = (req_reg.per_source_limit == '0) ? LW'(1) : LW'(req_reg.per_source_limit);
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            psq_pkg::entry_t l_ent, r_ent;
            logic            l_vld, r_vld, l_swap;
            if (gi == 0)
            begin : g_first
                assign l_ent  = '0;
                assign l_vld  = 1'b0;
                assign l_swap = 1'b0;
            end
            else
            begin : g_mid
                assign l_ent  = cell_ent[gi-1];
                assign l_vld  = cell_vld[gi-1];
                assign l_swap = cell_swap[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign r_ent = '0;
                assign r_vld = 1'b0;
            end
            else
            begin : g_inner
                assign r_ent = cell_ent[gi+1];
                assign r_vld = cell_vld[gi+1];
            end

            psq_cell #(
                .CELL_INDEX (gi),
                .DEPTH      (QUEUE_DEPTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_ent   (l_ent),
                .left_vld   (l_vld),
                .swap_left  (l_swap),
                .right_ent  (r_ent),
                .right_vld  (r_vld),
                .ent        (cell_ent[gi]),
                .vld        (cell_vld[gi]),
                .swap_right (cell_swap[gi]),
                .m          (cell_m[gi])
            );

            assign vec_id[gi]   = cell_m[gi].id;
            assign vec_src[gi]  = cell_m[gi].src;
            assign vec_conv[gi] = cell_m[gi].conv;
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psq_pkg::S_IDLE:  if (in_valid) state_next = psq_pkg::S_LOAD;
            psq_pkg::S_LOAD:  state_next = psq_pkg::S_SCAN;
            psq_pkg::S_SCAN:  if (last_round) state_next = psq_pkg::S_APPLY;
            psq_pkg::S_APPLY: state_next = psq_pkg::S_SORT;
            psq_pkg::S_SORT:  if (last_round) state_next = psq_pkg::S_RESP;
            psq_pkg::S_RESP:  if (out_ready) state_next = psq_pkg::S_IDLE;
            default:          state_next = psq_pkg::S_IDLE;
        endcase
    end

    // datapath control and decisions
    always_comb
    begin
        cmd.op      = psq_pkg::CELL_HOLD;
        cmd.parity  = cnt_reg[0];
        cmd.key     = new_ent;
        cnt_next    = '0;
        occ_next    = occ_reg;
        rsp_next    = rsp_reg;
        a_cnt_next  = a_cnt_reg;
        b_cnt_next  = b_cnt_reg;
        flag_a_next = flag_a_reg;
        flag_b_next = flag_b_reg;

        unique case (state_reg)
            psq_pkg::S_LOAD:
            begin
                // snapshot per-cell matches; removals by conversation count conv matches
                flag_a_next = vec_id;
                flag_b_next = (req_reg.kind == psq_pkg::KIND_RM_CONV) ? vec_conv : vec_src;
                a_cnt_next  = '0;
                b_cnt_next  = '0;
            end
            psq_pkg::S_SCAN:
            begin
                // flags march toward cell 0, counted one per cycle
                a_cnt_next  = a_cnt_reg + CW'(flag_a_reg[0]);
                b_cnt_next  = b_cnt_reg + CW'(flag_b_reg[0]);
                flag_a_next = flag_a_reg >> 1;
                flag_b_next = flag_b_reg >> 1;
                cnt_next    = last_round ? '0 : cnt_reg + RW'(1);
            end
            psq_pkg::S_APPLY:
            begin
                rsp_next        = '0;
                rsp_next.status = psq_pkg::ST_NOT_FOUND;
                unique case (req_reg.kind)
                    psq_pkg::KIND_ENQ:
                    begin
                        if (req_reg.response_id == '0)
                        begin
                            rsp_next.status = psq_pkg::ST_BAD_ID;
                        end
                        else if (req_reg.conversation_id == '0 || req_reg.source_id == '0)
                        begin
                            rsp_next.status = psq_pkg::ST_NO_TAG;
                        end
                        else if (req_reg.text_empty)
                        begin
                            rsp_next.status = psq_pkg::ST_EMPTY_TEXT;
                        end
                        else if (a_cnt_reg != '0)
                        begin
                            rsp_next.status = psq_pkg::ST_DUPLICATE;
                        end
                        else if (LW'(occ_reg) >= total_lim)
                        begin
                            rsp_next.status = psq_pkg::ST_FULL;
                        end
                        else if (LW'(b_cnt_reg) >= src_lim)
                        begin
                            rsp_next.status = psq_pkg::ST_SRC_FULL;
                        end
                        else
                        begin
                            // last cell is free; the sort pass moves the entry into place
                            rsp_next.status = psq_pkg::ST_OK;
                            cmd.op          = psq_pkg::CELL_LOAD_NEW;
                            occ_next        = occ_reg + CW'(1);
                        end
                    end
                    psq_pkg::KIND_RM_ID:
                    begin
                        rsp_next.removed_count = psq_pkg::CNT_OUT_W'(a_cnt_reg);
                        if (a_cnt_reg != '0)
                        begin
                            rsp_next.status = psq_pkg::ST_OK;
                        end
                        cmd.op   = psq_pkg::CELL_DROP_ID;
                        occ_next = occ_reg - a_cnt_reg;
                    end
                    psq_pkg::KIND_RM_SRC, psq_pkg::KIND_RM_CONV:
                    begin
                        rsp_next.removed_count = psq_pkg::CNT_OUT_W'(b_cnt_reg);
                        if (b_cnt_reg != '0)
                        begin
                            rsp_next.status = psq_pkg::ST_OK;
                        end
                        cmd.op   = (req_reg.kind == psq_pkg::KIND_RM_SRC) ?
                                   psq_pkg::CELL_DROP_SRC : psq_pkg::CELL_DROP_CONV;
                        occ_next = occ_reg - b_cnt_reg;
                    end
                    psq_pkg::KIND_REPRIO:
                    begin
                        if (a_cnt_reg != '0)
                        begin
                            rsp_next.status = psq_pkg::ST_OK;
                            cmd.op          = psq_pkg::CELL_SET_PRIO;
                        end
                    end
                    psq_pkg::KIND_POP, psq_pkg::KIND_PEEK:
                    begin
                        if (cell_vld[0])
                        begin
                            rsp_next.status           = psq_pkg::ST_OK;
                            rsp_next.out_id           = cell_ent[0].id;
                            rsp_next.out_conversation = cell_ent[0].conv;
                            rsp_next.out_source       = cell_ent[0].src;
                            rsp_next.out_priority     = cell_ent[0].prio;
                            rsp_next.out_time         = cell_ent[0].tstamp;
                            if (req_reg.kind == psq_pkg::KIND_POP)
                            begin
                                cmd.op   = psq_pkg::CELL_DROP_HEAD;
                                occ_next = occ_reg - CW'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            psq_pkg::S_SORT:
            begin
                // stable odd-even transposition: valid first, then by priority and time
                cmd.op   = psq_pkg::CELL_SORT;
                cnt_next = last_round ? '0 : cnt_reg + RW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psq_pkg::S_IDLE;
            cnt_reg   <= '0;
            occ_reg   <= '0;
            total_reg <= psq_pkg::TOTAL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            occ_reg   <= occ_next;
            if (cfg_valid && cfg_ready)
            begin
                total_reg <= cfg_data;
            end
        end
    end

    // request and scan payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        rsp_reg    <= rsp_next;
        a_cnt_reg  <= a_cnt_next;
        b_cnt_reg  <= b_cnt_next;
        flag_a_reg <= flag_a_next;
        flag_b_reg <= flag_b_next;
    end

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request taken while a response is pending");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_head_matches_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psq_pkg::S_IDLE) |-> (cell_vld[0] == (occ_reg != '0)))
        else $error("head cell validity disagrees with occupancy");

    a_sort_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psq_pkg::S_APPLY) |=> (state_reg == psq_pkg::S_SORT && cnt_reg == '0))
        else $error("sort pass did not follow apply");

endmodule

// File: src/psq_cell.sv
// psq_cell: one queue slot with valid bit, key match and odd-even swap logic
// depends on psq_pkg
`timescale 1ns / 1ps

module psq_cell #(
    parameter int CELL_INDEX = 0,
    parameter int DEPTH      = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  psq_pkg::cell_cmd_t cmd,
    input  psq_pkg::entry_t    left_ent,
    input  logic               left_vld,
    input  logic               swap_left,
    input  psq_pkg::entry_t    right_ent,
    input  logic               right_vld,
    output psq_pkg::entry_t    ent,
    output logic               vld,
    output logic               swap_right,
    output psq_pkg::match_t    m
);

    localparam bit IS_FIRST = (CELL_INDEX == 0);
    localparam bit IS_LAST  = (CELL_INDEX == DEPTH - 1);
    localparam bit IS_ODD   = (CELL_INDEX % 2) == 1;

    psq_pkg::entry_t ent_reg, ent_next;
    logic            vld_reg, vld_next;
    logic            pair_on;

    assign ent = ent_reg;
    assign vld = vld_reg;

    assign m.id   = vld_reg && (ent_reg.id == cmd.key.id);
    assign m.src  = vld_reg && (ent_reg.src == cmd.key.src);
    assign m.conv = vld_reg && (ent_reg.conv == cmd.key.conv);

    // pair (this, right) compares on rounds of matching parity
    assign pair_on = (cmd.op == psq_pkg::CELL_SORT) && !IS_LAST && (cmd.parity == IS_ODD);
    assign swap_right = pair_on && right_vld &&
                        (!vld_reg || psq_pkg::goes_before(right_ent, ent_reg));

    always_comb
    begin
        ent_next = ent_reg;
        vld_next = vld_reg;
        unique case (cmd.op)
            psq_pkg::CELL_SORT:
            begin
                if (swap_right)
                begin
                    ent_next = right_ent;
                    vld_next = right_vld;
                end
                else if (swap_left)
                begin
                    ent_next = left_ent;
                    vld_next = left_vld;
                end
            end
            psq_pkg::CELL_LOAD_NEW:
            begin
                if (IS_LAST)
                begin
                    ent_next = cmd.key;
                    vld_next = 1'b1;
                end
            end
            psq_pkg::CELL_DROP_ID:   if (m.id)   vld_next = 1'b0;
            psq_pkg::CELL_DROP_SRC:  if (m.src)  vld_next = 1'b0;
            psq_pkg::CELL_DROP_CONV: if (m.conv) vld_next = 1'b0;
            psq_pkg::CELL_SET_PRIO:  if (m.id)   ent_next.prio = cmd.key.prio;
            psq_pkg::CELL_DROP_HEAD: if (IS_FIRST) vld_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

endmodule

// File: tb/priority_queue_with_source_quota_top_tb.sv
// testbench for priority_queue_with_source_quota_top: random and directed queue requests
// checked against a sorted-queue predictor; depends on psq_pkg and the block's RTL
`timescale 1ns / 1ps

module priority_queue_with_source_quota_top_tb;

    localparam int DEPTH = 64;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    psq_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    psq_pkg::rsp_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [psq_pkg::LIMIT_W-1:0] cfg_data = '0;

    priority_queue_with_source_quota_top #(.QUEUE_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // shadow copy of the queue, kept in sorted order
    psq_pkg::entry_t shadow_q[$];
    logic [psq_pkg::LIMIT_W-1:0] total_limit;

    psq_pkg::req_t pending_reqs[$];
    psq_pkg::rsp_t expected_rsps[$];
    int error_count = 0;
    longint cycle_count = 0;
    bit hold_sender = 1'b0;

    // small pools so duplicates, quotas and removals hit often
    logic [psq_pkg::ID_W-1:0] id_pool[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic bit ahead_of(psq_pkg::entry_t a, psq_pkg::entry_t b);
        if (a.prio != b.prio)
            return a.prio > b.prio;
        return a.tstamp < b.tstamp;
    endfunction

    // computes the response for one request and updates the shadow queue
    function automatic psq_pkg::rsp_t queue_response(psq_pkg::req_t r);
        psq_pkg::rsp_t rsp;
        psq_pkg::entry_t e;
        psq_pkg::entry_t kept[$];
        int lim, slim, cnt, pos, n;
        bit hit;
        rsp = '0;
        rsp.status = psq_pkg::ST_NOT_FOUND;
        case (r.kind)
            psq_pkg::KIND_ENQ:
            begin
                lim = (total_limit < 1) ? 1 :
                      ((total_limit > DEPTH) ? DEPTH : int'(total_limit));
                slim = (r.per_source_limit < 1) ? 1 : int'(r.per_source_limit);
                hit = 1'b0;
                cnt = 0;
                foreach (shadow_q[i])
                begin
                    if (shadow_q[i].id == r.response_id) hit = 1'b1;
                    if (shadow_q[i].src == r.source_id) cnt++;
                end
                if (r.response_id == 0) rsp.status = psq_pkg::ST_BAD_ID;
                else if (r.conversation_id == 0 || r.source_id == 0)
                    rsp.status = psq_pkg::ST_NO_TAG;
                else if (r.text_empty) rsp.status = psq_pkg::ST_EMPTY_TEXT;
                else if (hit) rsp.status = psq_pkg::ST_DUPLICATE;
                else if (shadow_q.size() >= lim) rsp.status = psq_pkg::ST_FULL;
                else if (cnt >= slim) rsp.status = psq_pkg::ST_SRC_FULL;
                else
                begin
                    e.id = r.response_id;
                    e.conv = r.conversation_id;
                    e.src = r.source_id;
                    e.prio = r.priority_req;
                    e.tstamp = r.created_time;
                    pos = 0;
                    while (pos < shadow_q.size() && !ahead_of(e, shadow_q[pos])) pos++;
                    shadow_q.insert(pos, e);
                    rsp.status = psq_pkg::ST_OK;
                end
            end
            psq_pkg::KIND_RM_ID, psq_pkg::KIND_RM_SRC, psq_pkg::KIND_RM_CONV:
            begin
                n = 0;
                foreach (shadow_q[i])
                begin
                    if ((r.kind == psq_pkg::KIND_RM_ID && shadow_q[i].id == r.response_id) ||
                        (r.kind == psq_pkg::KIND_RM_SRC && shadow_q[i].src == r.source_id) ||
                        (r.kind == psq_pkg::KIND_RM_CONV &&
                         shadow_q[i].conv == r.conversation_id))
                        n++;
                    else
                        kept.push_back(shadow_q[i]);
                end
                shadow_q = kept;
                rsp.removed_count = psq_pkg::CNT_OUT_W'(n);
                rsp.status = (n > 0) ? psq_pkg::ST_OK : psq_pkg::ST_NOT_FOUND;
            end
            psq_pkg::KIND_REPRIO:
            begin
                pos = -1;
                foreach (shadow_q[i])
                    if (pos < 0 && shadow_q[i].id == r.response_id) pos = i;
                if (pos >= 0)
                begin
                    shadow_q[pos].prio = r.priority_req;
                    // stable insertion sort
                    for (int i = 1; i < shadow_q.size(); i++)
                    begin
                        e = shadow_q[i];
                        n = i;
                        while (n > 0 && ahead_of(e, shadow_q[n-1]))
                        begin
                            shadow_q[n] = shadow_q[n-1];
                            n--;
                        end
                        shadow_q[n] = e;
                    end
                    rsp.status = psq_pkg::ST_OK;
                end
            end
            psq_pkg::KIND_POP, psq_pkg::KIND_PEEK:
            begin
                if (shadow_q.size() > 0)
                begin
                    rsp.status = psq_pkg::ST_OK;
                    rsp.out_id = shadow_q[0].id;
                    rsp.out_conversation = shadow_q[0].conv;
                    rsp.out_source = shadow_q[0].src;
                    rsp.out_priority = shadow_q[0].prio;
                    rsp.out_time = shadow_q[0].tstamp;
                    if (r.kind == psq_pkg::KIND_POP) void'(shadow_q.pop_front());
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // build one request with content drawn from small pools
    function automatic psq_pkg::req_t make_req(int kind_weight_enq);
        psq_pkg::req_t r;
        int p;
        r = '0;
        p = $urandom_range(0, 99);
        if (p < kind_weight_enq) r.kind = psq_pkg::KIND_ENQ;
        else r.kind = psq_pkg::kind_t'($urandom_range(1, 7));
        if (id_pool.size() > 0 && $urandom_range(0, 2) == 0)
            r.response_id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else if ($urandom_range(0, 30) == 0)
            r.response_id = $urandom_range(0, 1) ? '0 : '1;
        else
            r.response_id = $urandom;
        r.conversation_id = ($urandom_range(0, 40) == 0) ? 16'd0 :
                            ($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 6)));
        r.source_id = ($urandom_range(0, 40) == 0) ? 16'd0 :
                      ($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 5)));
        // few priority levels so equal keys happen, wide values sometimes
        r.priority_req = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                         16'((int'($urandom_range(0, 4)) - 2) * 256);
        r.created_time = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 7));
        r.text_empty = ($urandom_range(0, 30) == 0);
        r.per_source_limit = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 20));
        if (r.kind == psq_pkg::KIND_ENQ && r.response_id != 0) id_pool.push_back(r.response_id);
        if (id_pool.size() > 80) void'(id_pool.pop_front());
        return r;
    endfunction

    // driver: takes requests from the pending queue with random gaps
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_rsps.push_back(queue_response(in_data));
                send_gap = gap_len();
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_reqs.size() > 0 && send_gap == 0 && !hold_sender)
                begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    // monitor: random back-pressure and field-by-field compare
    int stall = 0;
    psq_pkg::rsp_t want;
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected response", 64'(out_data.status), 64'(0));
                else
                begin
                    want = expected_rsps.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", 64'(out_data.status), 64'(want.status));
                    if (out_data.out_id !== want.out_id)
                        report_mismatch("out_id", 64'(out_data.out_id), 64'(want.out_id));
                    if (out_data.out_conversation !== want.out_conversation)
                        report_mismatch("out_conversation", 64'(out_data.out_conversation),
                                        64'(want.out_conversation));
                    if (out_data.out_source !== want.out_source)
                        report_mismatch("out_source", 64'(out_data.out_source),
                                        64'(want.out_source));
                    if (out_data.out_priority !== want.out_priority)
                        report_mismatch("out_priority", 64'(out_data.out_priority),
                                        64'(want.out_priority));
                    if (out_data.out_time !== want.out_time)
                        report_mismatch("out_time", 64'(out_data.out_time), 64'(want.out_time));
                    if (out_data.removed_count !== want.removed_count)
                        report_mismatch("removed_count", 64'(out_data.removed_count),
                                        64'(want.removed_count));
                end
                stall = gap_len();
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // wait until every request is sent and answered, then let the block settle
    // checked at the falling edge, once all edge updates have landed
    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [psq_pkg::LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        total_limit = v;
    endtask

    function automatic psq_pkg::req_t enq_req(logic [psq_pkg::ID_W-1:0] id,
                                              logic [psq_pkg::TAG_W-1:0] cv,
                                              logic [psq_pkg::TAG_W-1:0] sr,
                                              logic [psq_pkg::PRIO_W-1:0] pr,
                                              logic [psq_pkg::TIME_W-1:0] tm);
        psq_pkg::req_t r;
        r = '0;
        r.kind = psq_pkg::KIND_ENQ;
        r.response_id = id;
        r.conversation_id = cv;
        r.source_id = sr;
        r.priority_req = pr;
        r.created_time = tm;
        r.per_source_limit = 7'd64;
        return r;
    endfunction

    psq_pkg::req_t r;
    int settings[6] = '{64, 127, 1, 0, 5, 20};

    initial
    begin
        total_limit = psq_pkg::TOTAL_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every rejection but a full queue, equal keys, extreme fields, all kinds
        pending_reqs.push_back(enq_req(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(enq_req(32'd1, 16'd1, 16'd1, 16'h8000, 32'd0));
        pending_reqs.push_back(enq_req(32'd2, 16'd1, 16'd2, 16'h0100, 32'd5));
        pending_reqs.push_back(enq_req(32'd3, 16'd2, 16'd2, 16'h0100, 32'd5));
        pending_reqs.push_back(enq_req(32'd4, 16'd2, 16'd3, 16'h0100, 32'd4));
        pending_reqs.push_back(enq_req(32'd0, 16'd1, 16'd1, 16'h0, 32'd0));
        pending_reqs.push_back(enq_req(32'd9, 16'd0, 16'd1, 16'h0, 32'd0));
        pending_reqs.push_back(enq_req(32'd9, 16'd1, 16'd0, 16'h0, 32'd0));
        r = enq_req(32'd9, 16'd1, 16'd1, 16'h0, 32'd0);
        r.text_empty = 1'b1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(enq_req(32'd2, 16'd1, 16'd2, 16'h0, 32'd0));
        r = enq_req(32'd10, 16'd1, 16'd2, 16'h0, 32'd0);
        r.per_source_limit = 7'd0;
        pending_reqs.push_back(r);
        r = '0; r.kind = psq_pkg::KIND_REPRIO; r.response_id = 32'd1; r.priority_req = 16'h0100;
        pending_reqs.push_back(r);
        r.response_id = 32'd77;
        pending_reqs.push_back(r);
        r = '0; r.kind = psq_pkg::KIND_PEEK; pending_reqs.push_back(r);
        r.kind = psq_pkg::KIND_POP; pending_reqs.push_back(r);
        r = '0; r.kind = psq_pkg::KIND_RM_ID; r.response_id = 32'd3; pending_reqs.push_back(r);
        r = '0; r.kind = psq_pkg::KIND_RM_SRC; r.source_id = 16'd2; pending_reqs.push_back(r);
        r = '0; r.kind = psq_pkg::KIND_RM_CONV; r.conversation_id = 16'd1;
        pending_reqs.push_back(r);
        r.conversation_id = 16'd0; pending_reqs.push_back(r);
        r = '0; r.kind = psq_pkg::kind_t'(3'd7); pending_reqs.push_back(r);
        r = '0; r.kind = psq_pkg::KIND_POP; pending_reqs.push_back(r);
        pending_reqs.push_back(r);
        pending_reqs.push_back(r);
        drain();

        // random phases across limit settings; the sender holds off once mid-phase
        foreach (settings[s])
        begin
            write_limit(psq_pkg::LIMIT_W'(settings[s]));
            for (int i = 0; i < 175; i++)
                pending_reqs.push_back(make_req(s == 0 ? 60 : 45));
            if (s == 2)
            begin
                while (pending_reqs.size() > 90) @(posedge clk);
                hold_sender = 1'b1;
                @(negedge clk);
                while (in_valid || expected_rsps.size() > 0) @(negedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: files.f
src/psq_pkg.sv
src/psq_cell.sv
src/priority_queue_with_source_quota_top.sv
tb/priority_queue_with_source_quota_top_tb.sv
